/* hw/rtl/pan_tilt_aim_controller_unit_defines.svh */
// assertion helpers shared by the aim controller rtl
`ifndef PAN_TILT_AIM_CONTROLLER_UNIT_DEFINES_SVH
`define PAN_TILT_AIM_CONTROLLER_UNIT_DEFINES_SVH

// condition must hold in the same cycle
`define PTAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the following cycle
`define PTAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ptac_pkg.sv */
package ptac_pkg;

  localparam int ANGLE_W  = 8;
  localparam int STICK_W  = 10;
  localparam int OFFSET_W = 12;
  localparam int GAIN_W   = 17;
  localparam int PROD_W   = OFFSET_W + GAIN_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int FRAC_W   = 16;
  localparam int WHOLE_W  = SUM_W - FRAC_W;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 3;

  // command opcodes
  localparam logic [1:0] OP_JOYSTICK  = 2'd0;
  localparam logic [1:0] OP_CALIBRATE = 2'd1;
  localparam logic [1:0] OP_TRACK     = 2'd2;
  localparam logic [1:0] OP_MANUAL    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAN_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_LOWER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_UPPER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_LOWER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_UPPER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_LOW     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_HIGH    = 3'd7;

  // reset values
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = -17'sd3932;
  localparam logic [ANGLE_W-1:0] LOWER_RESET  = 8'd10;
  localparam logic [ANGLE_W-1:0] UPPER_RESET  = 8'd170;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET  = 8'd90;
  localparam logic [STICK_W-1:0] DZ_LOW_RESET  = 10'd450;
  localparam logic [STICK_W-1:0] DZ_HIGH_RESET = 10'd570;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic [STICK_W-1:0]         stick_x;
    logic [STICK_W-1:0]         stick_y;
    logic signed [OFFSET_W-1:0] offset_x;
    logic signed [OFFSET_W-1:0] offset_y;
  } cmd_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] pan_out;
    logic [ANGLE_W-1:0] tilt_out;
    logic               tracking_active;
    logic               angles_updated;
  } aim_t;

  // control from the merge stage to each axis lane
  typedef struct packed {
    logic load;
    logic advance;
    logic do_step;
    logic do_track;
    logic do_cal;
  } lane_ctrl_t;

  // when the limits cross, values below the lower limit get it and all others get the upper limit
  function automatic logic [ANGLE_W-1:0] clamp_angle(
    input logic signed [WHOLE_W-1:0] x,
    input logic [ANGLE_W-1:0]        lo,
    input logic [ANGLE_W-1:0]        hi
  );
    logic [ANGLE_W-1:0] res;
    if (x < $signed({{(WHOLE_W-ANGLE_W){1'b0}}, lo})) begin
      res = lo;
    end else if (x > $signed({{(WHOLE_W-ANGLE_W){1'b0}}, hi})) begin
      res = hi;
    end else begin
      res = x[ANGLE_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/ptac_axis_lane.sv */
module ptac_axis_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ptac_pkg::lane_ctrl_t                  ctrl,
  input  logic [ptac_pkg::STICK_W-1:0]          reading,
  input  logic signed [ptac_pkg::OFFSET_W-1:0]  offset,
  input  logic signed [ptac_pkg::GAIN_W-1:0]    gain,
  input  logic [ptac_pkg::ANGLE_W-1:0]          lower,
  input  logic [ptac_pkg::ANGLE_W-1:0]          upper,
  input  logic [ptac_pkg::STICK_W-1:0]          dz_low,
  input  logic [ptac_pkg::STICK_W-1:0]          dz_high,
  output logic [ptac_pkg::ANGLE_W-1:0]          angle,
  output logic                                  moving
);

  localparam int PW = ptac_pkg::PROD_W;
  localparam int SW = ptac_pkg::SUM_W;
  localparam int FW = ptac_pkg::FRAC_W;
  localparam int WW = ptac_pkg::WHOLE_W;
  localparam int AW = ptac_pkg::ANGLE_W;

  logic signed [PW-1:0] prod;
  logic                 step_dn;
  logic                 step_up;
  logic [AW-1:0]        reference;

  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] biased;
  logic signed [WW-1:0] whole;
  logic signed [WW-1:0] stepped;
  logic [AW-1:0]        track_angle;
  logic [AW-1:0]        step_angle;

  // stage one: gain product and deadzone decision
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod    <= PW'(offset) * PW'(gain);
      step_dn <= reading < dz_low;
      step_up <= (reading >= dz_low) && (reading > dz_high);
    end
  end

  assign moving = step_dn | step_up;

  // stage two: reference plus product, truncated toward zero; also the joystick step, both clamped to the limits
  always_comb begin
    sum    = SW'(prod) + $signed({{(SW-AW-FW){1'b0}}, reference, {FW{1'b0}}});
    biased = sum + (sum[SW-1] ? $signed(SW'({FW{1'b1}})) : $signed(SW'(0)));
    whole  = biased[SW-1:FW];
    stepped = $signed({{(WW-AW){1'b0}}, angle})
            + (step_dn ? -WW'(1) : (step_up ? WW'(1) : WW'(0)));
    track_angle = ptac_pkg::clamp_angle(whole, lower, upper);
    step_angle  = ptac_pkg::clamp_angle(stepped, lower, upper);
  end

  // angle and reference state
  always_ff @(posedge clk) begin
    if (rst) begin
      angle     <= ptac_pkg::ANGLE_RESET;
      reference <= ptac_pkg::ANGLE_RESET;
    end else if (ctrl.advance) begin
      if (ctrl.do_step) begin
        angle <= step_angle;
      end else if (ctrl.do_track) begin
        angle <= track_angle;
      end
      if (ctrl.do_cal) begin
        reference <= angle;
      end
    end
  end

endmodule

/* hw/rtl/pan_tilt_aim_controller_unit.sv */
// pan/tilt aim controller: pan and tilt lanes run side by side
// a command beat is held in stage one, then its result lands in the angle and mode registers that form the result beat
// throughput: one command per cycle while the result side takes beats
// the multiply register in each lane sets the two-stage depth
// reset (rst, synchronous): angles and references 90, manual mode, registers to defaults
`include "pan_tilt_aim_controller_unit_defines.svh"

module pan_tilt_aim_controller_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  ptac_pkg::cmd_t                      cmd,
  output logic                                aim_valid,
  input  logic                                aim_stall,
  output ptac_pkg::aim_t                      aim,
  input  logic                                cfg_wr_en,
  input  logic [ptac_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [ptac_pkg::CFG_W-1:0]          cfg_wr_data
);

  localparam int AW = ptac_pkg::ANGLE_W;
  localparam int XW = ptac_pkg::STICK_W;
  localparam int GW = ptac_pkg::GAIN_W;

  logic signed [GW-1:0] pan_gain;
  logic signed [GW-1:0] tilt_gain;
  logic [AW-1:0]        pan_lower;
  logic [AW-1:0]        pan_upper;
  logic [AW-1:0]        tilt_lower;
  logic [AW-1:0]        tilt_upper;
  logic [XW-1:0]        dz_low;
  logic [XW-1:0]        dz_high;

  logic                 s1_valid;
  logic [1:0]           s1_op;
  logic                 s1_move;
  logic                 load;
  logic                 tracking;
  logic                 updated;
  logic                 pan_moving;
  logic                 tilt_moving;
  logic [AW-1:0]        pan_angle;
  logic [AW-1:0]        tilt_angle;
  ptac_pkg::lane_ctrl_t ctrl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_gain   <= ptac_pkg::GAIN_RESET;
      tilt_gain  <= ptac_pkg::GAIN_RESET;
      pan_lower  <= ptac_pkg::LOWER_RESET;
      pan_upper  <= ptac_pkg::UPPER_RESET;
      tilt_lower <= ptac_pkg::LOWER_RESET;
      tilt_upper <= ptac_pkg::UPPER_RESET;
      dz_low     <= ptac_pkg::DZ_LOW_RESET;
      dz_high    <= ptac_pkg::DZ_HIGH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        ptac_pkg::REG_PAN_GAIN:   pan_gain   <= $signed(cfg_wr_data[GW-1:0]);
        ptac_pkg::REG_TILT_GAIN:  tilt_gain  <= $signed(cfg_wr_data[GW-1:0]);
        ptac_pkg::REG_PAN_LOWER:  pan_lower  <= cfg_wr_data[AW-1:0];
        ptac_pkg::REG_PAN_UPPER:  pan_upper  <= cfg_wr_data[AW-1:0];
        ptac_pkg::REG_TILT_LOWER: tilt_lower <= cfg_wr_data[AW-1:0];
        ptac_pkg::REG_TILT_UPPER: tilt_upper <= cfg_wr_data[AW-1:0];
        ptac_pkg::REG_DZ_LOW:     dz_low     <= cfg_wr_data[XW-1:0];
        ptac_pkg::REG_DZ_HIGH:    dz_high    <= cfg_wr_data[XW-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake: stage one refills as soon as it moves on
  assign s1_move   = s1_valid && (!aim_valid || !aim_stall);
  assign cmd_stall = s1_valid && !s1_move;
  assign load      = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_op <= cmd.opcode;
    end
  end

  // merge: decide what both lanes do with the beat in stage one
  always_comb begin
    ctrl.load     = load;
    ctrl.advance  = s1_move;
    ctrl.do_step  = (s1_op == ptac_pkg::OP_JOYSTICK) && !tracking
                    && (pan_moving || tilt_moving);
    ctrl.do_track = (s1_op == ptac_pkg::OP_TRACK) && tracking;
    ctrl.do_cal   = (s1_op == ptac_pkg::OP_CALIBRATE);
  end

  ptac_axis_lane u_pan (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .reading (cmd.stick_x),
    .offset  (cmd.offset_x),
    .gain    (pan_gain),
    .lower   (pan_lower),
    .upper   (pan_upper),
    .dz_low  (dz_low),
    .dz_high (dz_high),
    .angle   (pan_angle),
    .moving  (pan_moving)
  );

  ptac_axis_lane u_tilt (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .reading (cmd.stick_y),
    .offset  (cmd.offset_y),
    .gain    (tilt_gain),
    .lower   (tilt_lower),
    .upper   (tilt_upper),
    .dz_low  (dz_low),
    .dz_high (dz_high),
    .angle   (tilt_angle),
    .moving  (tilt_moving)
  );

  // mode, update flag and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tracking  <= 1'b0;
      updated   <= 1'b0;
      aim_valid <= 1'b0;
    end else if (s1_move) begin
      aim_valid <= 1'b1;
      updated   <= ctrl.do_step || ctrl.do_track;
      case (s1_op)
        ptac_pkg::OP_CALIBRATE: tracking <= 1'b1;
        ptac_pkg::OP_MANUAL:    tracking <= 1'b0;
        default: begin
        end
      endcase
    end else if (!aim_stall) begin
      aim_valid <= 1'b0;
    end
  end

  // the state registers double as the result register
  assign aim.pan_out         = pan_angle;
  assign aim.tilt_out        = tilt_angle;
  assign aim.tracking_active = tracking;
  assign aim.angles_updated  = updated;

  `PTAC_ASSERT_NOW(a_stall_needs_full, cmd_stall, s1_valid && aim_valid && aim_stall, "stall without full pipe")
  `PTAC_ASSERT_NEXT(a_state_holds, !s1_move, $stable(pan_angle) && $stable(tilt_angle) && $stable(tracking), "state moved without a beat")
  `PTAC_ASSERT_NOW(a_result_from_stage, $rose(aim_valid), $past(s1_move), "result beat without source")
  `PTAC_ASSERT_NEXT(a_stage_holds, s1_valid && !s1_move, s1_valid, "stage one beat lost")

endmodule
